### hw/rtl/sm4_pkg.sv
// SM4 shared types, constants and round functions.
// Used by the key expander and the top-level data pipeline; no dependencies.
package sm4_pkg;

    localparam int BLOCK_W = 128;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 5;
    localparam int TDATA_IN_W = 136;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BLOCK_W-1:0] block_t;

    // APB register indexes (paddr[4:3])
    localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW      = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic word_t sub_word(input word_t v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic word_t rotl(input word_t v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic word_t t_key(input word_t v);
        word_t b;
        b = sub_word(v);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    function automatic word_t t_data(input word_t v);
        word_t b;
        b = sub_word(v);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // CK byte j of word i is (4i + j) * 7 mod 256
    function automatic word_t ck_word(input logic [7:0] idx);
        word_t      w;
        logic [7:0] b;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = 8'((idx << 2) + 8'(j));
            w = {w[23:0], 8'(b * 8'd7)};
        end
        return w;
    endfunction

    // One round on the window {X0, X1, X2, X3}, X0 in the top word
    function automatic block_t sm4_round(input block_t x, input word_t rk);
        word_t nx;
        nx = x[127:96] ^ t_data(x[95:64] ^ x[63:32] ^ x[31:0] ^ rk);
        return {x[95:0], nx};
    endfunction

endpackage

### hw/rtl/sm4_key_expand.sv
// SM4 key schedule: one round key per cycle into a register file.
// Depends on sm4_pkg for FK, CK, S-box and T'.
module sm4_key_expand
    import sm4_pkg::*;
#(
    parameter int ROUNDS = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   restart,
    input  block_t key,
    output word_t  round_keys [ROUNDS],
    output logic   keys_ready
);

    localparam int CW = $clog2(ROUNDS);

    logic          pending_reg;
    logic          busy_reg;
    logic          ready_reg;
    logic [CW-1:0] cnt_reg;
    word_t         k_reg [4];
    word_t         rk_reg [ROUNDS];
    word_t         nk;

    assign nk = k_reg[0] ^ t_key(k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ ck_word(8'(cnt_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b1;
            busy_reg    <= 1'b0;
            ready_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (restart)
        begin
            // key registers change this edge; load them next cycle
            pending_reg <= 1'b1;
            busy_reg    <= 1'b0;
            ready_reg   <= 1'b0;
        end
        else if (pending_reg)
        begin
            pending_reg <= 1'b0;
            busy_reg    <= 1'b1;
            cnt_reg     <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(ROUNDS - 1))
            begin
                busy_reg  <= 1'b0;
                ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pending_reg && !restart)
        begin
            k_reg[0] <= key[127:96] ^ FK0;
            k_reg[1] <= key[95:64]  ^ FK1;
            k_reg[2] <= key[63:32]  ^ FK2;
            k_reg[3] <= key[31:0]   ^ FK3;
        end
        else if (busy_reg && !restart)
        begin
            k_reg[0]        <= k_reg[1];
            k_reg[1]        <= k_reg[2];
            k_reg[2]        <= k_reg[3];
            k_reg[3]        <= nk;
            rk_reg[cnt_reg] <= nk;
        end
    end

    assign round_keys = rk_reg;
    assign keys_ready = ready_reg;

endmodule

### hw/rtl/sm4_block_cipher.sv
// SM4 ECB engine, one round per pipeline stage: an input register plus 32
// round stages; throughput one block per cycle while the output is not stalled.
// The rate is set by the round pipeline; the key schedule runs after reset
// or a key write, during which no block is accepted.
// Reset (rst_n low, async) clears key, mode, valid bits and key-ready flag.
module sm4_block_cipher
    import sm4_pkg::*;
#(
    parameter int ROUNDS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // block_high [63:0], block_low [127:64], byte_count [132:128]
    input  logic [TDATA_IN_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_high [63:0], result_low [127:64]
    output logic [BLOCK_W-1:0]    m_tdata
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        decrypt_reg;
    logic        wr_en;
    logic        key_wr;
    word_t       round_keys [ROUNDS];
    logic        keys_ready;
    logic        advance;
    block_t      in_block;
    block_t      masked;
    logic [4:0]  byte_count;
    logic        valid_reg [ROUNDS+1];
    block_t      data_reg  [ROUNDS+1];

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign key_wr = wr_en && (paddr[4:3] == REG_KEY_HIGH || paddr[4:3] == REG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            decrypt_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[4:3])
                REG_KEY_HIGH:     key_high_reg <= pwdata;
                REG_KEY_LOW:      key_low_reg  <= pwdata;
                REG_DECRYPT_MODE: decrypt_reg  <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_KEY_HIGH:     prdata = key_high_reg;
            REG_KEY_LOW:      prdata = key_low_reg;
            REG_DECRYPT_MODE: prdata = {63'b0, decrypt_reg};
            default:          prdata = '0;
        endcase
    end

    sm4_key_expand #(.ROUNDS(ROUNDS)) u_key_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (key_wr),
        .key        ({key_high_reg, key_low_reg}),
        .round_keys (round_keys),
        .keys_ready (keys_ready)
    );

    // the whole pipeline moves together; hold everything when the output stalls
    assign advance  = !valid_reg[ROUNDS] || m_tready;
    assign s_tready = advance && keys_ready;

    assign in_block   = {s_tdata[63:0], s_tdata[127:64]};
    assign byte_count = s_tdata[132:128];

    // zero bytes at or beyond the count when encrypting
    always_comb
    begin
        masked = in_block;
        for (int k = 0; k < 16; k++)
        begin
            if (!decrypt_reg && !(5'(k) < byte_count))
                masked[BLOCK_W-1-8*k -: 8] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= ROUNDS; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= s_tvalid && s_tready;
            for (int s = 1; s <= ROUNDS; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg[0] <= masked;
    end

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        word_t rk;
        assign rk = decrypt_reg ? round_keys[ROUNDS-1-r] : round_keys[r];
        always_ff @(posedge clk)
        begin
            if (advance)
                data_reg[r+1] <= sm4_round(data_reg[r], rk);
        end
    end

    assign m_tvalid = valid_reg[ROUNDS];
    // result is the final window in reverse word order
    assign m_tdata  = {data_reg[ROUNDS][95:64], data_reg[ROUNDS][127:96],
                       data_reg[ROUNDS][31:0],  data_reg[ROUNDS][63:32]};

endmodule

### tb/sv/sm4_block_cipher_checker.sv
// Scoreboard for the SM4 ECB engine: follows APB writes, predicts every result
// from its own key schedule and round model, and compares output transfers.
// Depends on sm4_pkg for widths and register indexes.
module sm4_block_cipher_checker
    import sm4_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_IN_W-1:0] s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [BLOCK_W-1:0]    m_tdata,
    output int                    errors,
    output int                    pending
);

    logic [7:0] sb [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    logic [63:0]  key_hi, key_lo;
    logic         decrypting;
    logic         schedule_valid;
    logic [31:0]  round_keys [32];
    logic [127:0] expected_blocks [$];
    int           mismatches;

    function automatic logic [31:0] rot(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] subst(input logic [31:0] v);
        return {sb[v[31:24]], sb[v[23:16]], sb[v[15:8]], sb[v[7:0]]};
    endfunction

    task automatic expand_schedule();
        logic [31:0] k [4];
        logic [31:0] ck, b, nk;
        k[0] = key_hi[63:32] ^ 32'ha3b1bac6;
        k[1] = key_hi[31:0]  ^ 32'h56aa3350;
        k[2] = key_lo[63:32] ^ 32'h677d9197;
        k[3] = key_lo[31:0]  ^ 32'hb27022dc;
        for (int i = 0; i < 32; i++)
        begin
            for (int j = 0; j < 4; j++)
                ck[31-8*j -: 8] = 8'((4 * i + j) * 7);
            b  = subst(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ b ^ rot(b, 13) ^ rot(b, 23);
            round_keys[i] = nk;
            k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
        end
        schedule_valid = 1'b1;
    endtask

    function automatic logic [127:0] cipher_block(input logic [63:0] hi,
                                                  input logic [63:0] lo,
                                                  input logic [4:0] count);
        logic [31:0]  x [4];
        logic [31:0]  b, nx, rk;
        logic [127:0] be;
        int           n;
        if (!decrypting)
        begin
            n  = (count > 16) ? 16 : count;
            be = {hi, lo};
            // zero bytes at or beyond the valid count
            for (int i = 0; i < 16; i++)
                if (i >= n)
                    be[127-8*i -: 8] = 8'h00;
            hi = be[127:64];
            lo = be[63:0];
        end
        x[0] = hi[63:32]; x[1] = hi[31:0]; x[2] = lo[63:32]; x[3] = lo[31:0];
        for (int i = 0; i < 32; i++)
        begin
            rk = decrypting ? round_keys[31 - i] : round_keys[i];
            b  = subst(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ b ^ rot(b, 2) ^ rot(b, 10) ^ rot(b, 18) ^ rot(b, 24);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
        end
        return {x[1], x[0], x[3], x[2]};
    endfunction

    assign errors  = mismatches;

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            key_hi = '0;
            key_lo = '0;
            decrypting = 1'b0;
            schedule_valid = 1'b0;
            expected_blocks.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:3])
                    REG_KEY_HIGH:
                    begin
                        key_hi = pwdata;
                        schedule_valid = 1'b0;
                    end
                    REG_KEY_LOW:
                    begin
                        key_lo = pwdata;
                        schedule_valid = 1'b0;
                    end
                    REG_DECRYPT_MODE: decrypting = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (!schedule_valid)
                    expand_schedule();
                expected_blocks.push_back(cipher_block(s_tdata[63:0], s_tdata[127:64],
                                                       s_tdata[132:128]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer %h", m_tdata);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (m_tdata[63:0] !== want[63:0] || m_tdata[127:64] !== want[127:64])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: hi exp %h got %h, lo exp %h got %h",
                                     want[63:0], m_tdata[63:0], want[127:64],
                                     m_tdata[127:64]);
                    end
                end
            end
            pending = expected_blocks.size();
        end
    end

endmodule

### tb/sv/sm4_block_cipher_tb.sv
// Top of the SM4 ECB engine testbench: clock, reset, APB key writes, block
// stimulus with bursts and output stalls. Depends on sm4_pkg and the checker.
module sm4_block_cipher_tb;
    import sm4_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [4:0]            paddr;
    logic [63:0]           pwdata;
    logic [63:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_IN_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BLOCK_W-1:0]    m_tdata;
    int                    errors;
    int                    pending;
    int                    stall_mode;
    logic                  hold_req;

    sm4_block_cipher dut (.*);

    sm4_block_cipher_checker scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one block, holding it until the transfer.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] count);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, count, lo, hi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [4:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 5'd16;
        if (r == 9)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 16));
    endfunction

    // Receiver: random stalls, runs of always-ready, and one long hold-off.
    initial
    begin
        int   hold_left;
        logic hold_done;
        m_tready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    initial
    begin
        logic [4:0] cnt;
        int         sent;
        int         burst;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        stall_mode = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset key, standard test vector, count extremes, decrypt.
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16);
        s_tvalid <= 1'b0;
        drain();
        reg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
        reg_write(REG_KEY_LOW, 64'hfedcba9876543210);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16);
        for (int c = 0; c <= 17; c += (c < 9 ? 1 : 4))
            send_block('1, '1, 5'(c));
        send_block('1, '1, 5'd31);
        send_block('0, '0, 5'd16);
        s_tvalid <= 1'b0;
        drain();
        reg_write(REG_DECRYPT_MODE, 64'd1);
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 5'd0);
        send_block('1, '1, 5'd3);
        s_tvalid <= 1'b0;
        drain();
        reg_write(REG_KEY_HIGH, '1);
        reg_write(REG_KEY_LOW, '1);
        reg_write(REG_DECRYPT_MODE, 64'd0);

        sent = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            stall_mode = phase % 3;
            if (phase == 3)
                hold_req = 1'b1;
            while (sent < 230 * (phase + 1))
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++)
                begin
                    cnt = rand_count();
                    send_block(rand64(), rand64(), cnt);
                    sent++;
                end
                if ($urandom_range(0, 1))
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            s_tvalid <= 1'b0;
            drain();
            reg_write(REG_DECRYPT_MODE, 64'($urandom_range(0, 1)));
            if (phase % 2 == 0)
                reg_write(REG_KEY_HIGH, rand64());
            if (phase % 3 != 2)
                reg_write(REG_KEY_LOW, rand64());
        end

        stall_mode = 0;
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
